FILE: sv/hdi_pkg.sv
// ----------------------------------------------------------------------------
// hdi_pkg: shared types and constants
// Widths, words passed between the front and back halves, and the saturation
// helpers of the HSI derivative invariants block.
// ----------------------------------------------------------------------------
package hdi_pkg;

  // square root operand and result widths
  localparam int SQW = 36;
  localparam int SRW = 18;
  // numerator widths (cross term, radial term, rounded magnitude)
  localparam int NHW = 36;
  localparam int NSW = 37;
  localparam int NUMW = 38;
  // quotient bits kept before clamping
  localparam int QW = 24;
  // queue depth between the halves and at the result side
  localparam int QDEPTH = 2;

  localparam logic [23:0] OUT_MAX = 24'h7fffff;
  localparam logic [23:0] OUT_MIN = 24'h800000;
  localparam logic [16:0] LEVEL_MAX = 17'h1ffff;

  // one input word
  typedef struct packed {
    logic [15:0]        red_smooth;
    logic [15:0]        green_smooth;
    logic [15:0]        blue_smooth;
    logic signed [15:0] red_grad_x;
    logic signed [15:0] red_grad_y;
    logic signed [15:0] green_grad_x;
    logic signed [15:0] green_grad_y;
    logic signed [15:0] blue_grad_x;
    logic signed [15:0] blue_grad_y;
  } pix_t;

  // word handed from the front half to the back half
  typedef struct packed {
    logic signed [NHW-1:0] nh_x;
    logic signed [NHW-1:0] nh_y;
    logic signed [NSW-1:0] ns_x;
    logic signed [NSW-1:0] ns_y;
    logic                  zero;
    logic                  vneg_x;
    logic                  vneg_y;
    logic [SRW-1:0]        s1;
    logic [SRW-1:0]        s3;
    logic [SRW-1:0]        lt;
    logic [SRW-1:0]        it_x;
    logic [SRW-1:0]        it_y;
  } mid_t;

  // one result word
  typedef struct packed {
    logic signed [23:0] hue_deriv_x;
    logic signed [23:0] hue_deriv_y;
    logic signed [23:0] sat_deriv_x;
    logic signed [23:0] sat_deriv_y;
    logic signed [23:0] inten_deriv_x;
    logic signed [23:0] inten_deriv_y;
    logic [16:0]        sat_level;
  } res_t;

  // magnitude of a signed numerator
  function automatic logic [NUMW-1:0] mag_num(input logic signed [NUMW-1:0] v);
    logic signed [NUMW-1:0] n;
    begin
      n = -v;
      return (v < 0) ? NUMW'(n) : NUMW'(v);
    end
  endfunction

  // signed quotient with clamping, forced to zero on zero saturation
  function automatic logic [23:0] sat_quot(input logic zero, input logic ovf,
                                           input logic neg, input logic [QW-1:0] q);
    begin
      if (zero) return '0;
      if (!neg) return (ovf || q[QW-1]) ? OUT_MAX : q;
      if (ovf || q > OUT_MIN) return OUT_MIN;
      return 24'(-q);
    end
  endfunction

  // rounded half of a root, with sign applied
  function automatic logic [23:0] round_signed(input logic neg, input logic [SRW-1:0] t);
    logic [SRW-1:0] m;
    begin
      m = (t + SRW'(1)) >> 1;
      return neg ? 24'(-24'(m)) : 24'(m);
    end
  endfunction

endpackage

FILE: sv/hdi_fifo.sv
// ----------------------------------------------------------------------------
// hdi_fifo: two-entry word queue
// Small register queue that lets the writing and reading sides stall apart.
// ----------------------------------------------------------------------------
module hdi_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [hdi_pkg::QDEPTH];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == 2'(hdi_pkg::QDEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/hdi_isqrt.sv
// ----------------------------------------------------------------------------
// hdi_isqrt: pipelined scaled integer square root
// Finds the largest t with MULT*t*t <= x, one result bit per stage.
// ----------------------------------------------------------------------------
module hdi_isqrt #(
  parameter int WX   = 36,
  parameter int WR   = 18,
  parameter int MULT = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [WX-1:0] x_i,
  output logic [WR-1:0] t_o
);

  localparam int WT = WX + 4;

  logic [WR-1:0] t_q   [WR];
  logic [WX-1:0] rem_q [WR];

  for (genvar i = 0; i < WR; i++) begin : g_stage
    localparam int K = WR - 1 - i;
    logic [WR-1:0] t_in;
    logic [WX-1:0] rem_in;
    logic [WT-1:0] base, term;
    logic          take;

    if (i == 0) begin : g_first
      assign t_in   = '0;
      assign rem_in = x_i;
    end else begin : g_next
      assign t_in   = t_q[i-1];
      assign rem_in = rem_q[i-1];
    end

    // growth of MULT*t^2 when this bit is set
    assign base = (WT'(t_in) << (K + 1)) + (WT'(1) << (2 * K));
    assign term = base * WT'(MULT);
    assign take = WT'(rem_in) >= term;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[i]   <= take ? (t_in | (WR'(1) << K)) : t_in;
        rem_q[i] <= take ? (rem_in - WX'(term)) : rem_in;
      end
    end
  end

  assign t_o = t_q[WR-1];

endmodule

FILE: sv/hdi_div.sv
// ----------------------------------------------------------------------------
// hdi_div: pipelined restoring divider
// Unsigned quotient of QBITS bits, one bit per stage; needs n < d << QBITS.
// ----------------------------------------------------------------------------
module hdi_div #(
  parameter int NW    = 38,
  parameter int DW    = 18,
  parameter int QBITS = 24
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NW-1:0]    n_i,
  input  logic [DW-1:0]    d_i,
  output logic [QBITS-1:0] q_o
);

  localparam int W = DW + QBITS;

  logic [W-1:0]     rem_q [QBITS];
  logic [DW-1:0]    d_q   [QBITS];
  logic [QBITS-1:0] q_q   [QBITS];

  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    localparam int K = QBITS - 1 - i;
    logic [W-1:0]     rem_in, dsh;
    logic [DW-1:0]    d_in;
    logic [QBITS-1:0] q_in;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = W'(n_i);
      assign d_in   = d_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign d_in   = d_q[i-1];
      assign q_in   = q_q[i-1];
    end

    // trial subtract of the shifted divisor
    assign dsh  = W'(d_in) << K;
    assign take = rem_in >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? (rem_in - dsh) : rem_in;
        d_q[i]   <= d_in;
        q_q[i]   <= take ? (q_in | (QBITS'(1) << K)) : q_in;
      end
    end
  end

  assign q_o = q_q[QBITS-1];

endmodule

FILE: sv/hdi_front.sv
// ----------------------------------------------------------------------------
// hdi_front: input capture, products and square roots
// Takes input words, forms differences, products and sums, then runs the
// saturation, level and intensity roots alongside the numerators.
// ----------------------------------------------------------------------------
module hdi_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hdi_pkg::pix_t        pix_i,
  input  logic                 stall_i,
  output logic                 full_o,
  output logic                 valid_o,
  output hdi_pkg::mid_t        word_o
);

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};
  localparam int SRW = hdi_pkg::SRW;
  localparam int SQW = hdi_pkg::SQW;
  localparam int NHW = hdi_pkg::NHW;
  localparam int NSW = hdi_pkg::NSW;

  typedef struct packed {
    logic signed [NHW-1:0] nh_x;
    logic signed [NHW-1:0] nh_y;
    logic signed [NSW-1:0] ns_x;
    logic signed [NSW-1:0] ns_y;
    logic                  zero;
    logic                  vneg_x;
    logic                  vneg_y;
  } carry_t;

  logic en;
  assign en     = !stall_i;
  assign full_o = stall_i;

  // input capture
  hdi_pkg::pix_t in_q;
  logic          v0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= push_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) in_q <= pix_i;
  end

  // channel differences and derivative combinations
  logic [15:0]        ch [3];
  logic signed [15:0] gd [2][3];
  logic signed [16:0] dch_d [3];
  logic signed [16:0] eh_d  [2][3];
  logic signed [18:0] es_d  [2][3];
  logic signed [17:0] vs_d  [2];

  assign ch[0] = in_q.red_smooth;
  assign ch[1] = in_q.green_smooth;
  assign ch[2] = in_q.blue_smooth;
  assign gd[0][0] = in_q.red_grad_x;
  assign gd[1][0] = in_q.red_grad_y;
  assign gd[0][1] = in_q.green_grad_x;
  assign gd[1][1] = in_q.green_grad_y;
  assign gd[0][2] = in_q.blue_grad_x;
  assign gd[1][2] = in_q.blue_grad_y;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dch_d[c] = $signed({1'b0, ch[c]}) - $signed({1'b0, ch[NXT[c]]});
    end
    for (int a = 0; a < 2; a++) begin
      for (int c = 0; c < 3; c++) begin
        eh_d[a][c] = 17'(gd[a][PRV[c]]) - 17'(gd[a][NXT[c]]);
        es_d[a][c] = (19'(gd[a][c]) <<< 1) - 19'(gd[a][NXT[c]]) - 19'(gd[a][PRV[c]]);
      end
      vs_d[a] = 18'(gd[a][0]) + 18'(gd[a][1]) + 18'(gd[a][2]);
    end
  end

  logic [15:0]        ch1_q [3];
  logic signed [16:0] dch_q [3];
  logic signed [16:0] eh_q  [2][3];
  logic signed [18:0] es_q  [2][3];
  logic signed [17:0] vs_q  [2];
  logic               v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ch1_q <= ch;
      dch_q <= dch_d;
      eh_q  <= eh_d;
      es_q  <= es_d;
      vs_q  <= vs_d;
    end
  end

  // products
  logic signed [33:0] sq_d [3];
  logic signed [33:0] ph_d [2][3];
  logic signed [35:0] ps_d [2][3];
  logic signed [35:0] vv_d [2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq_d[c] = dch_q[c] * dch_q[c];
    end
    for (int a = 0; a < 2; a++) begin
      for (int c = 0; c < 3; c++) begin
        ph_d[a][c] = $signed({1'b0, ch1_q[c]}) * eh_q[a][c];
        ps_d[a][c] = $signed({1'b0, ch1_q[c]}) * es_q[a][c];
      end
      vv_d[a] = vs_q[a] * vs_q[a];
    end
  end

  logic [33:0]        sq_q [3];
  logic signed [33:0] ph_q [2][3];
  logic signed [35:0] ps_q [2][3];
  logic [34:0]        vv_q [2];
  logic               vn_q [2];
  logic               v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) sq_q[c] <= 34'(sq_d[c]);
      ph_q <= ph_d;
      ps_q <= ps_d;
      for (int a = 0; a < 2; a++) begin
        vv_q[a] <= 35'(vv_d[a]);
        vn_q[a] <= vs_q[a][17];
      end
    end
  end

  // sums and root operands
  logic [SQW-1:0] q_sum;
  logic [SQW-1:0] x_d [5];
  carry_t         c3_d;
  assign q_sum = SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
  always_comb begin
    x_d[0] = q_sum;
    x_d[1] = q_sum + (q_sum << 1);
    x_d[2] = q_sum << 2;
    x_d[3] = SQW'(vv_q[0]) << 2;
    x_d[4] = SQW'(vv_q[1]) << 2;
    c3_d.nh_x   = NHW'(ph_q[0][0]) + NHW'(ph_q[0][1]) + NHW'(ph_q[0][2]);
    c3_d.nh_y   = NHW'(ph_q[1][0]) + NHW'(ph_q[1][1]) + NHW'(ph_q[1][2]);
    c3_d.ns_x   = NSW'(ps_q[0][0]) + NSW'(ps_q[0][1]) + NSW'(ps_q[0][2]);
    c3_d.ns_y   = NSW'(ps_q[1][0]) + NSW'(ps_q[1][1]) + NSW'(ps_q[1][2]);
    c3_d.zero   = (q_sum == '0);
    c3_d.vneg_x = vn_q[0];
    c3_d.vneg_y = vn_q[1];
  end

  logic [SQW-1:0] x_q [5];
  carry_t         c3_q;
  logic           v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= x_d;
      c3_q <= c3_d;
    end
  end

  // root units: saturation, scaled saturation, level, intensity x and y
  logic [SRW-1:0] t [5];
  hdi_isqrt #(.WX(SQW), .WR(SRW), .MULT(1)) u_sqrt_s1 (
    .clk_i, .en_i(en), .x_i(x_q[0]), .t_o(t[0]));
  hdi_isqrt #(.WX(SQW), .WR(SRW), .MULT(1)) u_sqrt_s3 (
    .clk_i, .en_i(en), .x_i(x_q[1]), .t_o(t[1]));
  hdi_isqrt #(.WX(SQW), .WR(SRW), .MULT(3)) u_sqrt_lvl (
    .clk_i, .en_i(en), .x_i(x_q[2]), .t_o(t[2]));
  hdi_isqrt #(.WX(SQW), .WR(SRW), .MULT(3)) u_sqrt_ix (
    .clk_i, .en_i(en), .x_i(x_q[3]), .t_o(t[3]));
  hdi_isqrt #(.WX(SQW), .WR(SRW), .MULT(3)) u_sqrt_iy (
    .clk_i, .en_i(en), .x_i(x_q[4]), .t_o(t[4]));

  // numerators travel beside the roots
  carry_t cd_q [SRW];
  logic   vd_q [SRW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SRW; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v3_q;
      for (int i = 1; i < SRW; i++) vd_q[i] <= vd_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0] <= c3_q;
      for (int i = 1; i < SRW; i++) cd_q[i] <= cd_q[i-1];
    end
  end

  // word to the back half
  assign valid_o = vd_q[SRW-1];
  always_comb begin
    word_o.nh_x   = cd_q[SRW-1].nh_x;
    word_o.nh_y   = cd_q[SRW-1].nh_y;
    word_o.ns_x   = cd_q[SRW-1].ns_x;
    word_o.ns_y   = cd_q[SRW-1].ns_y;
    word_o.zero   = cd_q[SRW-1].zero;
    word_o.vneg_x = cd_q[SRW-1].vneg_x;
    word_o.vneg_y = cd_q[SRW-1].vneg_y;
    word_o.s1     = t[0];
    word_o.s3     = t[1];
    word_o.lt     = t[2];
    word_o.it_x   = t[3];
    word_o.it_y   = t[4];
  end

endmodule

FILE: sv/hdi_back.sv
// ----------------------------------------------------------------------------
// hdi_back: rounded division and output clamping
// Divides the hue and saturation numerators by their roots, rounds to
// nearest, clamps, and builds the result word.
// ----------------------------------------------------------------------------
module hdi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  hdi_pkg::mid_t word_i,
  output logic          take_o,
  input  logic          stall_i,
  output logic          valid_o,
  output hdi_pkg::res_t res_o
);

  localparam int NUMW = hdi_pkg::NUMW;
  localparam int SRW  = hdi_pkg::SRW;
  localparam int QW   = hdi_pkg::QW;
  localparam int WCMP = SRW + QW;

  typedef struct packed {
    logic [3:0]     ovf;
    logic [3:0]     neg;
    logic           zero;
    logic           vneg_x;
    logic           vneg_y;
    logic [SRW-1:0] lt;
    logic [SRW-1:0] it_x;
    logic [SRW-1:0] it_y;
  } bcar_t;

  logic en;
  assign en     = !stall_i;
  assign take_o = en && avail_i;

  // numerators with half divisor added, and overflow check
  logic signed [NUMW-1:0] num [4];
  logic [SRW-1:0]         den_d [4];
  logic [NUMW-1:0]        n_d [4];
  bcar_t                  c_d;
  always_comb begin
    num[0] = NUMW'(word_i.nh_x);
    num[1] = NUMW'(word_i.nh_y);
    num[2] = NUMW'(word_i.ns_x);
    num[3] = NUMW'(word_i.ns_y);
    den_d[0] = word_i.s1;
    den_d[1] = word_i.s1;
    den_d[2] = word_i.s3;
    den_d[3] = word_i.s3;
    for (int k = 0; k < 4; k++) begin
      n_d[k]      = hdi_pkg::mag_num(num[k]) + NUMW'(den_d[k] >> 1);
      c_d.neg[k]  = num[k][NUMW-1];
      c_d.ovf[k]  = WCMP'(n_d[k]) >= (WCMP'(den_d[k]) << QW);
    end
    c_d.zero   = word_i.zero;
    c_d.vneg_x = word_i.vneg_x;
    c_d.vneg_y = word_i.vneg_y;
    c_d.lt     = word_i.lt;
    c_d.it_x   = word_i.it_x;
    c_d.it_y   = word_i.it_y;
  end

  logic [NUMW-1:0] n_q [4];
  logic [SRW-1:0]  den_q [4];
  bcar_t           c1_q;
  logic            v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= avail_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q   <= n_d;
      den_q <= den_d;
      c1_q  <= c_d;
    end
  end

  // four dividers: hue x, hue y, saturation x, saturation y
  logic [QW-1:0] quo [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    hdi_div #(.NW(NUMW), .DW(SRW), .QBITS(QW)) u_div (
      .clk_i, .en_i(en), .n_i(n_q[k]), .d_i(den_q[k]), .q_o(quo[k]));
  end

  // side data delayed alongside the dividers
  bcar_t cd_q [QW];
  logic  vd_q [QW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v1_q;
      for (int i = 1; i < QW; i++) vd_q[i] <= vd_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0] <= c1_q;
      for (int i = 1; i < QW; i++) cd_q[i] <= cd_q[i-1];
    end
  end

  // clamp and assemble
  bcar_t          cl;
  logic [SRW-1:0] lv;
  assign cl      = cd_q[QW-1];
  assign valid_o = vd_q[QW-1];
  assign lv      = (cl.lt + SRW'(1)) >> 1;
  always_comb begin
    res_o.hue_deriv_x   = hdi_pkg::sat_quot(cl.zero, cl.ovf[0], cl.neg[0], quo[0]);
    res_o.hue_deriv_y   = hdi_pkg::sat_quot(cl.zero, cl.ovf[1], cl.neg[1], quo[1]);
    res_o.sat_deriv_x   = hdi_pkg::sat_quot(cl.zero, cl.ovf[2], cl.neg[2], quo[2]);
    res_o.sat_deriv_y   = hdi_pkg::sat_quot(cl.zero, cl.ovf[3], cl.neg[3], quo[3]);
    res_o.inten_deriv_x = hdi_pkg::round_signed(cl.vneg_x, cl.it_x);
    res_o.inten_deriv_y = hdi_pkg::round_signed(cl.vneg_y, cl.it_y);
    res_o.sat_level     = lv[SRW-1] ? hdi_pkg::LEVEL_MAX : lv[16:0];
  end

endmodule

FILE: sv/hsi_derivative_invariants_top.sv
// ----------------------------------------------------------------------------
// hsi_derivative_invariants_top: HSI spherical colour derivatives
// Per-pixel hue, saturation and intensity derivatives with saturation level.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock and one result word leaves per clock when
// both sides keep moving. A pixel passes through the 18-stage square root units
// in the front half and the 24-stage dividers in the back half. Each half stalls
// as a whole only when the two-entry queue after it is full, so full rises only
// after the result side has stopped popping for a while. No state survives
// between pixels; reset only empties the pipeline and queues.
module hsi_derivative_invariants_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        red_smooth_i,
  input  logic [15:0]        green_smooth_i,
  input  logic [15:0]        blue_smooth_i,
  input  logic signed [15:0] red_grad_x_i,
  input  logic signed [15:0] red_grad_y_i,
  input  logic signed [15:0] green_grad_x_i,
  input  logic signed [15:0] green_grad_y_i,
  input  logic signed [15:0] blue_grad_x_i,
  input  logic signed [15:0] blue_grad_y_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] hue_deriv_x_o,
  output logic signed [23:0] hue_deriv_y_o,
  output logic signed [23:0] sat_deriv_x_o,
  output logic signed [23:0] sat_deriv_y_o,
  output logic signed [23:0] inten_deriv_x_o,
  output logic signed [23:0] inten_deriv_y_o,
  output logic [16:0]        sat_level_o
);

  hdi_pkg::pix_t pix;
  hdi_pkg::mid_t f_word, m_word;
  hdi_pkg::res_t b_res, o_res;
  logic          f_valid, m_full, m_empty, m_pop;
  logic          b_valid, o_full;
  logic [$bits(hdi_pkg::mid_t)-1:0] m_rdata;
  logic [$bits(hdi_pkg::res_t)-1:0] o_rdata;

  // input word
  always_comb begin
    pix.red_smooth   = red_smooth_i;
    pix.green_smooth = green_smooth_i;
    pix.blue_smooth  = blue_smooth_i;
    pix.red_grad_x   = red_grad_x_i;
    pix.red_grad_y   = red_grad_y_i;
    pix.green_grad_x = green_grad_x_i;
    pix.green_grad_y = green_grad_y_i;
    pix.blue_grad_x  = blue_grad_x_i;
    pix.blue_grad_y  = blue_grad_y_i;
  end

  // front half
  hdi_front u_front (
    .clk_i, .rst_ni, .push_i(push), .pix_i(pix), .stall_i(m_full),
    .full_o(full), .valid_o(f_valid), .word_o(f_word));

  // queue between the halves
  hdi_fifo #(.WIDTH($bits(hdi_pkg::mid_t))) u_mid_q (
    .clk_i, .rst_ni, .push_i(f_valid && !m_full), .wdata_i(f_word),
    .pop_i(m_pop), .rdata_o(m_rdata), .full_o(m_full), .empty_o(m_empty));
  assign m_word = hdi_pkg::mid_t'(m_rdata);

  // back half
  hdi_back u_back (
    .clk_i, .rst_ni, .avail_i(!m_empty), .word_i(m_word), .take_o(m_pop),
    .stall_i(o_full), .valid_o(b_valid), .res_o(b_res));

  // result queue
  hdi_fifo #(.WIDTH($bits(hdi_pkg::res_t))) u_res_q (
    .clk_i, .rst_ni, .push_i(b_valid && !o_full), .wdata_i(b_res),
    .pop_i(pop), .rdata_o(o_rdata), .full_o(o_full), .empty_o(empty));
  assign o_res = hdi_pkg::res_t'(o_rdata);

  assign hue_deriv_x_o   = o_res.hue_deriv_x;
  assign hue_deriv_y_o   = o_res.hue_deriv_y;
  assign sat_deriv_x_o   = o_res.sat_deriv_x;
  assign sat_deriv_y_o   = o_res.sat_deriv_y;
  assign inten_deriv_x_o = o_res.inten_deriv_x;
  assign inten_deriv_y_o = o_res.inten_deriv_y;
  assign sat_level_o     = o_res.sat_level;

endmodule

FILE: sv/hdi_chk.sv
// ----------------------------------------------------------------------------
// hdi_chk: port checker
// Tracks words in flight from the ports and checks queue behaviour.
// ----------------------------------------------------------------------------
module hdi_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [23:0] hue_deriv_x_o,
  input logic [16:0]        sat_level_o
);

  logic [7:0] pend_q;
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  // words accepted and not yet popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 8'd0;
    else pend_q <= pend_q + 8'(acc_in) - 8'(acc_out);
  end

  // a result is only shown for a word taken earlier
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pend_q != 8'd0) else $error("result without pending word");

  // nothing in flight means room at the input
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 8'd0 |-> !full) else $error("full while idle");

  // a waiting result stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result dropped");

  // a waiting result keeps its value
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(hue_deriv_x_o) && $stable(sat_level_o)))
    else $error("result changed while waiting");

endmodule

bind hsi_derivative_invariants_top hdi_chk u_hdi_chk (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .hue_deriv_x_o, .sat_level_o);
